// ===== sv/qmv_pkg.sv =====
// Shared types and constants for the block-scaled int8 matrix-vector row engine.
package qmv_pkg;

    localparam int LANES     = 4;
    localparam int ACT_W     = 16;
    localparam int WQ_W      = 8;
    localparam int PROD_W    = ACT_W + WQ_W;
    localparam int LANESUM_W = PROD_W + $clog2(LANES);
    localparam int ACC_W     = 32;
    localparam int SCALE_W   = 16;
    localparam int BPROD_W   = ACC_W + SCALE_W;
    localparam int ROW_W     = 64;
    localparam int OUT_W     = 32;
    localparam int SHIFT_W   = 5;
    localparam int ADDR_W    = 2;
    localparam int DATA_W    = 32;

    localparam logic [SHIFT_W-1:0] SHIFT_RESET      = 5'd12;
    localparam logic [ADDR_W-1:0]  ADDR_SCALE_SHIFT = 2'd0;

    typedef struct packed {
        logic signed [ACT_W-1:0]   act_0;
        logic signed [ACT_W-1:0]   act_1;
        logic signed [ACT_W-1:0]   act_2;
        logic signed [ACT_W-1:0]   act_3;
        logic signed [WQ_W-1:0]    wq_0;
        logic signed [WQ_W-1:0]    wq_1;
        logic signed [WQ_W-1:0]    wq_2;
        logic signed [WQ_W-1:0]    wq_3;
        logic signed [SCALE_W-1:0] block_scale;
        logic                      block_end;
        logic                      row_end;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] row_sum;
        logic                    saturated;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic block_end;
        logic row_end;
    } t_ctl;

endpackage

// ===== sv/qmv_lane.sv =====
// One lane: registered signed activation times int8 weight product.
module qmv_lane (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [qmv_pkg::ACT_W-1:0]       i_act,
    input  logic signed [qmv_pkg::WQ_W-1:0]        i_wq,
    output logic signed [qmv_pkg::PROD_W-1:0]      o_prod
);

    logic signed [qmv_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_act * i_wq;
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== sv/qmv_merge.sv =====
// Merging stage: sums the lane products into the block accumulator and closes blocks.
module qmv_merge (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  qmv_pkg::t_ctl                          i_ctl,
    input  logic signed [qmv_pkg::PROD_W-1:0]      i_prods [qmv_pkg::LANES],
    input  logic signed [qmv_pkg::SCALE_W-1:0]     i_scale,
    output qmv_pkg::t_ctl                          o_ctl,
    output logic signed [qmv_pkg::ACC_W-1:0]       o_bsum,
    output logic signed [qmv_pkg::SCALE_W-1:0]     o_scale
);

    logic signed [qmv_pkg::LANESUM_W-1:0] lane_sum;
    logic signed [qmv_pkg::ACC_W-1:0]     n_blk;
    logic signed [qmv_pkg::ACC_W-1:0]     r_blk;
    logic signed [qmv_pkg::ACC_W-1:0]     r_bsum;
    logic signed [qmv_pkg::SCALE_W-1:0]   r_scale;
    qmv_pkg::t_ctl                        r_ctl;
    logic                                 closing;

    always_comb begin
        lane_sum = '0;
        for (int l = 0; l < qmv_pkg::LANES; l++) begin
            lane_sum = lane_sum + qmv_pkg::LANESUM_W'(i_prods[l]);
        end
    end

    // The block sum wraps modulo 2^32; a row end also closes the open block.
    assign n_blk   = r_blk + qmv_pkg::ACC_W'(lane_sum);
    assign closing = i_ctl.block_end | i_ctl.row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= '0;
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl.valid     <= i_ctl.valid & closing;
            r_ctl.block_end <= i_ctl.block_end;
            r_ctl.row_end   <= i_ctl.row_end;
            if (i_ctl.valid) begin
                r_blk <= closing ? '0 : n_blk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bsum  <= n_blk;
            r_scale <= i_scale;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_bsum  = r_bsum;
    assign o_scale = r_scale;

endmodule

// ===== sv/qmv_row.sv =====
// Row stages: block scaling, row accumulation, then shift, saturation and result register.
module qmv_row (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  qmv_pkg::t_ctl                          i_ctl,
    input  logic signed [qmv_pkg::ACC_W-1:0]       i_bsum,
    input  logic signed [qmv_pkg::SCALE_W-1:0]     i_scale,
    input  logic [qmv_pkg::SHIFT_W-1:0]            i_shift,
    output logic                                   o_valid,
    output qmv_pkg::t_out_item                     o_item
);

    qmv_pkg::t_ctl                        r_s3_ctl;
    logic signed [qmv_pkg::BPROD_W-1:0]   r_bprod;
    logic signed [qmv_pkg::ROW_W-1:0]     r_row;
    logic signed [qmv_pkg::ROW_W-1:0]     n_row;
    logic signed [qmv_pkg::ROW_W-1:0]     r_fin;
    logic                                 r_fin_valid;
    logic signed [qmv_pkg::ROW_W-1:0]     shifted;
    logic signed [qmv_pkg::OUT_W-1:0]     n_sum;
    logic                                 n_sat;
    logic                                 r_valid;
    qmv_pkg::t_out_item                   r_item;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bprod <= i_bsum * i_scale;
        end
    end

    assign n_row = r_row + qmv_pkg::ROW_W'(r_bprod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl    <= '0;
            r_row       <= '0;
            r_fin_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else if (i_en) begin
            r_s3_ctl    <= i_ctl;
            r_fin_valid <= r_s3_ctl.valid & r_s3_ctl.row_end;
            r_valid     <= r_fin_valid;
            if (r_s3_ctl.valid) begin
                r_row <= r_s3_ctl.row_end ? '0 : n_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin <= n_row;
        end
    end

    // Saturate when the bits above the 32-bit result are not all copies of its sign.
    always_comb begin
        shifted = r_fin >>> i_shift;
        n_sat   = 1'b0;
        n_sum   = shifted[qmv_pkg::OUT_W-1:0];
        if (shifted[qmv_pkg::ROW_W-1:qmv_pkg::OUT_W-1] != '0 &&
            shifted[qmv_pkg::ROW_W-1:qmv_pkg::OUT_W-1] != '1) begin
            n_sat = 1'b1;
            n_sum = shifted[qmv_pkg::ROW_W-1] ? {1'b1, {(qmv_pkg::OUT_W-1){1'b0}}}
                                               : {1'b0, {(qmv_pkg::OUT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item.row_sum   <= n_sum;
            r_item.saturated <= n_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== sv/block_quantized_int8_matvec_top.sv =====
// Top level of the block-scaled int8 matrix-vector row engine.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         i_in_valid / o_in_ready    i_in_data  (qmv_pkg::t_in_item)
//   output    out        o_out_valid / i_out_ready  o_out_data (qmv_pkg::t_out_item)
//   config    in         psel / penable / pready    paddr, pwdata, prdata (scale_shift)
//
// One item is taken per cycle, unless the output stalls, through four parallel lane multipliers and a merging adder.
// A row result passes the lane product, block sum, block product, row total and result registers in turn.
// While a result waits and the output is stalled, the whole pipeline holds.
// Reset clears both accumulators and sets scale_shift to 12.
module block_quantized_int8_matvec_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  qmv_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output qmv_pkg::t_out_item                 o_out_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [qmv_pkg::ADDR_W-1:0]         paddr,
    input  logic [qmv_pkg::DATA_W-1:0]         pwdata,
    output logic [qmv_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);

    logic                                 en;
    logic [qmv_pkg::SHIFT_W-1:0]          r_scale_shift;
    qmv_pkg::t_ctl                        r_s1_ctl;
    logic signed [qmv_pkg::SCALE_W-1:0]   r_s1_scale;
    logic signed [qmv_pkg::ACT_W-1:0]     acts  [qmv_pkg::LANES];
    logic signed [qmv_pkg::WQ_W-1:0]      wqs   [qmv_pkg::LANES];
    logic signed [qmv_pkg::PROD_W-1:0]    prods [qmv_pkg::LANES];
    qmv_pkg::t_ctl                        s2_ctl;
    logic signed [qmv_pkg::ACC_W-1:0]     s2_bsum;
    logic signed [qmv_pkg::SCALE_W-1:0]   s2_scale;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr == qmv_pkg::ADDR_SCALE_SHIFT)
                  ? qmv_pkg::DATA_W'(r_scale_shift) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_shift <= qmv_pkg::SHIFT_RESET;
        end else if (psel && penable && pwrite && paddr == qmv_pkg::ADDR_SCALE_SHIFT) begin
            r_scale_shift <= pwdata[qmv_pkg::SHIFT_W-1:0];
        end
    end

    // The pipeline advances unless a result is waiting for its transfer.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    assign acts[0] = i_in_data.act_0;
    assign acts[1] = i_in_data.act_1;
    assign acts[2] = i_in_data.act_2;
    assign acts[3] = i_in_data.act_3;
    assign wqs[0]  = i_in_data.wq_0;
    assign wqs[1]  = i_in_data.wq_1;
    assign wqs[2]  = i_in_data.wq_2;
    assign wqs[3]  = i_in_data.wq_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (en) begin
            r_s1_ctl.valid     <= i_in_valid;
            r_s1_ctl.block_end <= i_in_data.block_end;
            r_s1_ctl.row_end   <= i_in_data.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_scale <= i_in_data.block_scale;
        end
    end

    for (genvar l = 0; l < qmv_pkg::LANES; l++) begin : g_lane
        qmv_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_act  (acts[l]),
            .i_wq   (wqs[l]),
            .o_prod (prods[l])
        );
    end

    qmv_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (r_s1_ctl),
        .i_prods (prods),
        .i_scale (r_s1_scale),
        .o_ctl   (s2_ctl),
        .o_bsum  (s2_bsum),
        .o_scale (s2_scale)
    );

    qmv_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (s2_ctl),
        .i_bsum  (s2_bsum),
        .i_scale (s2_scale),
        .i_shift (r_scale_shift),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

endmodule

// ===== bench/qmv_row_checker.sv =====
// Predicts row results of the int8 matrix-vector engine and compares them with the output port.
module qmv_row_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  qmv_pkg::t_in_item          i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  qmv_pkg::t_out_item         i_out_data,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [qmv_pkg::ADDR_W-1:0] i_paddr,
    input  logic [qmv_pkg::DATA_W-1:0] i_pwdata,
    output int                         o_mismatches,
    output int                         o_rows_due
);

    localparam logic signed [qmv_pkg::ROW_W-1:0] SUM_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [qmv_pkg::ROW_W-1:0] SUM_MIN = -64'sh0000_0000_8000_0000;

    logic signed [qmv_pkg::ACC_W-1:0] blk_acc;
    logic signed [qmv_pkg::ROW_W-1:0] row_total;
    logic [qmv_pkg::SHIFT_W-1:0]      shift_amt;
    qmv_pkg::t_out_item               rows_expected[$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        o_mismatches++;
    endtask

    task automatic accumulate_item(input qmv_pkg::t_in_item item);
        logic signed [qmv_pkg::ACT_W-1:0]  acts[qmv_pkg::LANES];
        logic signed [qmv_pkg::WQ_W-1:0]   wts[qmv_pkg::LANES];
        logic signed [qmv_pkg::PROD_W-1:0] prod;
        logic signed [qmv_pkg::ROW_W-1:0]  shifted;
        qmv_pkg::t_out_item                row;
        acts = '{item.act_0, item.act_1, item.act_2, item.act_3};
        wts  = '{item.wq_0, item.wq_1, item.wq_2, item.wq_3};
        // The block sum wraps at 32 bits when a block end is missing for long enough.
        for (int i = 0; i < qmv_pkg::LANES; i++) begin
            prod    = acts[i] * wts[i];
            blk_acc = blk_acc + prod;
        end
        // A row end closes the pending block even without its own block end.
        if (item.block_end || item.row_end) begin
            row_total = row_total + blk_acc * $signed(item.block_scale);
            blk_acc   = '0;
        end
        if (item.row_end) begin
            shifted = row_total >>> shift_amt;
            if (shifted > SUM_MAX) begin
                row.row_sum   = SUM_MAX[qmv_pkg::OUT_W-1:0];
                row.saturated = 1'b1;
            end else if (shifted < SUM_MIN) begin
                row.row_sum   = SUM_MIN[qmv_pkg::OUT_W-1:0];
                row.saturated = 1'b1;
            end else begin
                row.row_sum   = shifted[qmv_pkg::OUT_W-1:0];
                row.saturated = 1'b0;
            end
            rows_expected.push_back(row);
            row_total = '0;
            blk_acc   = '0;
        end
    endtask

    task automatic check_row(input qmv_pkg::t_out_item got);
        qmv_pkg::t_out_item want;
        if (rows_expected.size() == 0) begin
            report_mismatch($sformatf("row result %0d arrived with none expected",
                                      got.row_sum));
        end else begin
            want = rows_expected.pop_front();
            if (got.row_sum !== want.row_sum)
                report_mismatch($sformatf("row_sum got %0d, want %0d",
                                          got.row_sum, want.row_sum));
            if (got.saturated !== want.saturated)
                report_mismatch($sformatf("saturated got %0b, want %0b (row_sum %0d)",
                                          got.saturated, want.saturated, want.row_sum));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            blk_acc      = '0;
            row_total    = '0;
            shift_amt    = qmv_pkg::SHIFT_RESET;
            o_mismatches = 0;
            rows_expected.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr == qmv_pkg::ADDR_SCALE_SHIFT)
                shift_amt = i_pwdata[qmv_pkg::SHIFT_W-1:0];
            if (i_in_valid && i_in_ready)
                accumulate_item(i_in_data);
            if (i_out_valid && i_out_ready)
                check_row(i_out_data);
        end
        o_rows_due = rows_expected.size();
    end

endmodule

// ===== bench/tb_top.sv =====
// Stimulus, clock, reset and verdict for the int8 matrix-vector engine testbench.
module tb_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int BLOCK_ITEMS    = 128 / qmv_pkg::LANES;
    localparam int PHASE_ITEMS    = 300;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    qmv_pkg::t_in_item          in_data = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b1;
    qmv_pkg::t_out_item         out_data;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [qmv_pkg::ADDR_W-1:0] paddr   = '0;
    logic [qmv_pkg::DATA_W-1:0] pwdata  = '0;
    logic [qmv_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    int   mismatches;
    int   rows_due;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   idle_cycles;
    int   sent;
    logic in_took  = 1'b0;
    logic out_took = 1'b0;
    logic cfg_took = 1'b0;

    always #5 i_clk = ~i_clk;

    block_quantized_int8_matvec_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    qmv_row_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_rows_due   (rows_due)
    );

    // Handshakes are registered so the stimulus can look at them safely at the falling edge.
    always @(posedge i_clk) begin
        in_took  <= in_valid && in_ready;
        out_took <= out_valid && out_ready;
        cfg_took <= psel && penable && pwrite && pready;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [qmv_pkg::ACT_W-1:0] pick_act();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            default: return qmv_pkg::ACT_W'($urandom);
        endcase
    endfunction

    function automatic logic [qmv_pkg::WQ_W-1:0] pick_wq();
        case ($urandom_range(7))
            0: return 8'h80;
            1: return 8'h7F;
            2: return '0;
            default: return qmv_pkg::WQ_W'($urandom);
        endcase
    endfunction

    function automatic qmv_pkg::t_in_item rand_item(input bit blk, input bit rw);
        qmv_pkg::t_in_item item;
        item.act_0       = pick_act();
        item.act_1       = pick_act();
        item.act_2       = pick_act();
        item.act_3       = pick_act();
        item.wq_0        = pick_wq();
        item.wq_1        = pick_wq();
        item.wq_2        = pick_wq();
        item.wq_3        = pick_wq();
        item.block_scale = pick_act();
        item.block_end   = blk;
        item.row_end     = rw;
        return item;
    endfunction

    function automatic qmv_pkg::t_in_item lanes_item(
        input logic [qmv_pkg::ACT_W-1:0]   act,
        input logic [qmv_pkg::WQ_W-1:0]    wq,
        input logic [qmv_pkg::SCALE_W-1:0] scale,
        input bit blk, input bit rw);
        qmv_pkg::t_in_item item;
        item = '{act_0: act, act_1: act, act_2: act, act_3: act,
                 wq_0: wq, wq_1: wq, wq_2: wq, wq_3: wq,
                 block_scale: scale, block_end: blk, row_end: rw};
        return item;
    endfunction

    task automatic push_item(input qmv_pkg::t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        do @(negedge i_clk); while (!in_took);
        sent++;
    endtask

    task automatic wait_rows_drained();
        in_valid = 1'b0;
        while (rows_due != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_shift(input logic [qmv_pkg::SHIFT_W-1:0] value);
        wait_rows_drained();
        psel   = 1'b1;
        pwrite = 1'b1;
        paddr  = qmv_pkg::ADDR_SCALE_SHIFT;
        pwdata = qmv_pkg::DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(negedge i_clk); while (!cfg_took);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Sends one row of nblocks blocks of blk_len items; close_last puts a block end on the
    // row end too. all_max fills every lane with the largest positive product.
    task automatic send_row(input int nblocks, input int blk_len, input bit close_last,
                            input bit all_max);
        bit                last;
        qmv_pkg::t_in_item item;
        for (int b = 0; b < nblocks; b++) begin
            for (int k = 0; k < blk_len; k++) begin
                last = (b == nblocks - 1) && (k == blk_len - 1);
                if (all_max)
                    item = lanes_item(16'h8000, 8'h80, 16'h7FFF, 1'b0, last);
                else
                    item = rand_item(1'b0, last);
                item.block_end = (k == blk_len - 1) && (!last || close_last);
                push_item(item);
            end
        end
    endtask

    initial begin
        sent = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset value of the shift: zero row, row ends with and without a block end.
        push_item(lanes_item(16'h0000, 8'h00, 16'h0000, 1'b1, 1'b1));
        push_item(lanes_item(16'h7FFF, 8'h7F, 16'h7FFF, 1'b1, 1'b0));
        push_item(lanes_item(16'h7FFF, 8'h7F, 16'h7FFF, 1'b0, 1'b1));
        push_item(lanes_item(16'h8000, 8'h80, 16'h8000, 1'b1, 1'b1));
        push_item(lanes_item(16'h8000, 8'h7F, 16'h8000, 1'b0, 1'b1));
        push_item(lanes_item(16'h0100, 8'h05, 16'h1000, 1'b1, 1'b0));
        push_item(lanes_item(16'hFF00, 8'h03, 16'h2000, 1'b0, 1'b0));
        push_item(lanes_item(16'h0001, 8'hFF, 16'h0000, 1'b0, 1'b1));
        push_item(rand_item(1'b1, 1'b0));
        push_item(rand_item(1'b0, 1'b1));

        // No shift: both saturation directions and a small exact row.
        write_shift(5'd0);
        push_item(lanes_item(16'h8000, 8'h80, 16'h7FFF, 1'b1, 1'b1));
        push_item(lanes_item(16'h8000, 8'h80, 16'h8000, 1'b1, 1'b1));
        push_item(lanes_item(16'h0001, 8'h01, 16'h0001, 1'b1, 1'b1));

        // Largest shift: large rows collapse to small values, small ones to 0 or -1.
        write_shift(5'd31);
        push_item(lanes_item(16'h8000, 8'h80, 16'h8000, 1'b1, 1'b1));
        push_item(lanes_item(16'h0001, 8'h01, 16'h0001, 1'b1, 1'b1));
        push_item(lanes_item(16'hFFFF, 8'h01, 16'h0001, 1'b1, 1'b1));

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_shift(5'd8);
                1: write_shift(5'd31);
                2: write_shift(5'd0);
                default: write_shift(qmv_pkg::SHIFT_W'($urandom_range(31)));
            endcase
            send_idle_pct  = (phase == 1) ? 67 : (phase == 3) ? 13 : 0;
            recv_stall_pct = (phase == 2) ? 67 : (phase == 3) ? 13 : 0;
            // A long block with no block end wraps the block sum.
            if (phase == 0)
                send_row(1, 5 * BLOCK_ITEMS, 1'b0, 1'b1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                case ($urandom_range(9))
                    0, 1, 2, 3: send_row($urandom_range(1, 2), BLOCK_ITEMS,
                                         $urandom_range(3) != 0, 1'b0);
                    9: repeat ($urandom_range(1, 4))
                        push_item(rand_item(bit'($urandom_range(1)),
                                            bit'($urandom_range(1))));
                    default: send_row($urandom_range(1, 3), $urandom_range(1, 3),
                                      bit'($urandom_range(1)), 1'b0);
                endcase
            end
        end

        wait_rows_drained();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Ends a hung run: counts cycles in which no transfer of any kind happens.
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(negedge i_clk);
            if (in_took || out_took || cfg_took || !i_rst_n)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
